// ===== hdl/nlr_pkg.sv =====
// Package: shared types, character codes and constants for the numeric literal recognizer.
`default_nettype none

package nlr_pkg;

    // Longest token, in characters, that the recognizer will scan.
    localparam logic [7:0] MAX_TOKEN_LEN = 8'd255;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_MEANS_HEX = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AT_MEANS_OCTAL = 2'd1;

    // Character codes.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_SEVEN      = 8'h37;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_D    = 8'h64;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_H    = 8'h68;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_Q    = 8'h71;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;
    localparam logic [3:0] HEX_LETTER_ADJ = 4'd9;

    typedef enum logic [2:0] {
        KIND_NUMBER      = 3'd0,
        KIND_HASH        = 3'd1,
        KIND_LOC_COUNTER = 3'd2,
        KIND_MODULO      = 3'd3,
        KIND_INVALID     = 3'd4
    } nlr_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCAN  = 2'd1,
        PH_DRAIN = 2'd2
    } nlr_phase_t;

    typedef enum logic [1:0] {
        BASE_2  = 2'd0,
        BASE_8  = 2'd1,
        BASE_16 = 2'd2
    } nlr_base_t;

    // Literal forms in priority order, highest priority first.
    typedef enum logic [2:0] {
        F_QUOTE = 3'd0,
        F_PDIG  = 3'd1,
        F_ZPFX  = 3'd2,
        F_SB    = 3'd3,
        F_SO    = 3'd4,
        F_SD    = 3'd5,
        F_SH    = 3'd6,
        F_DEC   = 3'd7
    } nlr_form_t;

    localparam int NUM_FORMS = 8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       token_start;
    } nlr_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [7:0]         length;
    } nlr_result_t;

    typedef struct packed {
        logic hash_means_hex;
        logic at_means_octal;
    } nlr_cfg_t;

    typedef struct packed {
        logic [7:0] lower;
        logic       is_word;
        logic       is_dec;
        logic       is_bin;
        logic       is_oct;
        logic       is_hex;
        logic [3:0] dval;
        logic       is_bitmap;
        logic       bitmap_bit;
    } nlr_class_t;

    typedef struct packed {
        nlr_phase_t           phase;
        logic [7:0]           char_count;
        logic [7:0]           lead_char;
        logic [7:0]           quote_char;
        logic [NUM_FORMS-1:0] form_alive;
        logic [NUM_FORMS-1:0] form_suffix;
        nlr_base_t            pfx_base;
        logic [31:0]          acc_prefixed;
        logic [31:0]          acc_binary;
        logic [31:0]          acc_octal;
        logic [31:0]          acc_decimal;
        logic [31:0]          acc_hex;
        logic                 best_valid;
        nlr_form_t            best_rank;
        logic [7:0]           best_len;
        logic [31:0]          best_value;
    } nlr_state_t;

endpackage

`default_nettype wire

// ===== hdl/nlr_char_class.sv =====
// Character classifier: case folding, digit classes and digit value of one byte.
`default_nettype none

module nlr_char_class
    import nlr_pkg::*;
(
    input  logic [7:0] char_code,
    output nlr_class_t cls
);

    logic [7:0] low;
    logic       is_letter;

    always_comb
    begin
        low = (char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) ? char_code + CASE_OFFSET
                                                            : char_code;
        is_letter = low inside {[CH_LOWER_A:CH_LOWER_Z]};

        cls.lower   = low;
        cls.is_dec  = char_code inside {[CH_ZERO:CH_NINE]};
        cls.is_bin  = char_code inside {[CH_ZERO:CH_ONE]};
        cls.is_oct  = char_code inside {[CH_ZERO:CH_SEVEN]};
        cls.is_hex  = cls.is_dec || (low inside {[CH_LOWER_A:CH_LOWER_F]});
        cls.is_word = cls.is_dec || is_letter
                      || (char_code == CH_UNDERSCORE) || (char_code == CH_DOT);
        // Letters a..f have low nibbles 1..6, so adding nine gives 10..15.
        cls.dval    = cls.is_dec ? char_code[3:0] : low[3:0] + HEX_LETTER_ADJ;
        cls.is_bitmap  = cls.is_bin || (char_code == CH_MINUS) || (char_code == CH_HASH);
        cls.bitmap_bit = (char_code == CH_ONE) || (char_code == CH_HASH);
    end

endmodule

`default_nettype wire

// ===== hdl/nlr_scan.sv =====
// Scan logic: next recognizer state and result for one registered character beat.
`default_nettype none

module nlr_scan
    import nlr_pkg::*;
(
    input  nlr_cfg_t    cfg,
    input  nlr_item_t   item,
    input  logic        item_valid,
    input  nlr_state_t  state,
    output nlr_state_t  state_next,
    output logic        result_valid,
    output nlr_result_t result
);

    typedef struct packed {
        logic kill;
        logic succ;
        logic seen;
    } sfx_res_t;

    function automatic logic [31:0] shift_in(input logic [31:0] acc, input nlr_base_t base,
                                             input logic [3:0] d);
        logic [31:0] r;
        case (base)
            BASE_2:  r = {acc[30:0], 1'b0} + {28'd0, d};
            BASE_8:  r = {acc[28:0], 3'b000} + {28'd0, d};
            BASE_16: r = {acc[27:0], 4'b0000} + {28'd0, d};
            default: r = acc;
        endcase
        return r;
    endfunction

    function automatic logic base_digit(input nlr_base_t base, input nlr_class_t cl);
        logic r;
        case (base)
            BASE_2:  r = cl.is_bin;
            BASE_8:  r = cl.is_oct;
            BASE_16: r = cl.is_hex;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // A form with a suffix letter: digits, then the letter, then a non-word character.
    function automatic sfx_res_t suffix_eval(input logic live, input logic seen,
                                             input logic ok, input logic match,
                                             input logic word);
        sfx_res_t r;
        r = '0;
        if (live)
        begin
            if (seen)
            begin
                r.kill = 1'b1;
                r.succ = !word;
            end
            else if (!ok)
            begin
                if (match)
                    r.seen = 1'b1;
                else
                    r.kill = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic nlr_kind_t op_kind(input logic [7:0] ch);
        nlr_kind_t k;
        case (ch)
            CH_HASH:    k = KIND_HASH;
            CH_DOLLAR:  k = KIND_LOC_COUNTER;
            CH_PERCENT: k = KIND_MODULO;
            default:    k = KIND_INVALID;
        endcase
        return k;
    endfunction

    nlr_class_t           cl;
    logic [7:0]           c;
    logic [7:0]           pos;
    logic [7:0]           pos_inc;
    logic                 at_limit;
    logic [NUM_FORMS-1:0] alive;
    logic [NUM_FORMS-1:0] kill;
    logic [NUM_FORMS-1:0] succ;
    logic [NUM_FORMS-1:0] sfx_set;
    logic                 pfx_ok;
    logic                 q_open;
    nlr_base_t            z_base;
    logic                 z_base_ok;
    sfx_res_t             r_sb;
    sfx_res_t             r_so;
    sfx_res_t             r_sd;
    sfx_res_t             r_sh;
    logic [31:0]          acc_p_next;
    logic [31:0]          acc_b_next;
    logic [31:0]          acc_o_next;
    logic [31:0]          acc_d_next;
    logic [31:0]          acc_h_next;
    nlr_form_t            win;
    logic                 succ_any;
    logic                 take;
    logic [NUM_FORMS-1:0] keep_mask;
    logic [NUM_FORMS-1:0] alive_after;
    logic                 best_valid_after;
    nlr_form_t            best_rank_after;
    logic [7:0]           best_len_after;
    logic [31:0]          best_value_after;
    logic [31:0]          win_value;
    logic                 start_known;
    logic [NUM_FORMS-1:0] start_alive;
    nlr_base_t            start_base;
    logic [31:0]          start_bin;
    logic [31:0]          start_oct;
    logic [31:0]          start_dec;
    nlr_kind_t            lead_op;

    assign c        = item.char_code;
    assign pos      = state.char_count;
    assign pos_inc  = pos + 8'd1;
    assign at_limit = pos >= MAX_TOKEN_LEN;
    assign alive    = state.form_alive;
    assign lead_op  = op_kind(state.lead_char);

    nlr_char_class u_class (
        .char_code (c),
        .cls       (cl)
    );

    // Per-form evaluation of the current character.
    always_comb
    begin
        pfx_ok    = base_digit(state.pfx_base, cl);
        q_open    = (c == CH_SQUOTE) || (c == CH_DQUOTE);
        z_base    = BASE_2;
        z_base_ok = 1'b1;
        case (cl.lower)
            CH_LOWER_B: z_base = BASE_2;
            CH_LOWER_O: z_base = BASE_8;
            CH_LOWER_Q: z_base = BASE_8;
            CH_LOWER_X: z_base = BASE_16;
            default:    z_base_ok = 1'b0;
        endcase

        kill    = '0;
        succ    = '0;
        sfx_set = '0;

        if (alive[F_QUOTE])
        begin
            if (pos == 8'd1)
            begin
                kill[F_QUOTE] = !q_open;
            end
            else if (!cl.is_bitmap)
            begin
                kill[F_QUOTE] = 1'b1;
                succ[F_QUOTE] = (pos > 8'd2) && (c == state.quote_char)
                                && (pos < MAX_TOKEN_LEN);
            end
        end

        if (alive[F_PDIG] && !pfx_ok)
        begin
            kill[F_PDIG] = 1'b1;
            succ[F_PDIG] = (pos > 8'd1) && !cl.is_word;
        end

        if (alive[F_ZPFX])
        begin
            if (pos == 8'd1)
            begin
                kill[F_ZPFX] = !z_base_ok;
            end
            else if (!pfx_ok)
            begin
                kill[F_ZPFX] = 1'b1;
                succ[F_ZPFX] = (pos > 8'd2) && !cl.is_word;
            end
        end

        r_sb = suffix_eval(alive[F_SB], state.form_suffix[F_SB], cl.is_bin,
                           cl.lower == CH_LOWER_B, cl.is_word);
        r_so = suffix_eval(alive[F_SO], state.form_suffix[F_SO], cl.is_oct,
                           (cl.lower == CH_LOWER_O) || (cl.lower == CH_LOWER_Q), cl.is_word);
        r_sd = suffix_eval(alive[F_SD], state.form_suffix[F_SD], cl.is_dec,
                           cl.lower == CH_LOWER_D, cl.is_word);
        r_sh = suffix_eval(alive[F_SH], state.form_suffix[F_SH], cl.is_hex,
                           cl.lower == CH_LOWER_H, cl.is_word);
        {kill[F_SB], succ[F_SB], sfx_set[F_SB]} = r_sb;
        {kill[F_SO], succ[F_SO], sfx_set[F_SO]} = r_so;
        {kill[F_SD], succ[F_SD], sfx_set[F_SD]} = r_sd;
        {kill[F_SH], succ[F_SH], sfx_set[F_SH]} = r_sh;

        if (alive[F_DEC] && !cl.is_dec)
        begin
            kill[F_DEC] = 1'b1;
            succ[F_DEC] = !cl.is_word;
        end
    end

    // Accumulators. A success always comes on a non-digit, so it reports
    // the accumulator value from before this character.
    always_comb
    begin
        acc_p_next = state.acc_prefixed;
        if (alive[F_QUOTE] && (pos != 8'd1) && cl.is_bitmap)
            acc_p_next = {state.acc_prefixed[30:0], cl.bitmap_bit};
        else if (alive[F_PDIG] && pfx_ok)
            acc_p_next = shift_in(state.acc_prefixed, state.pfx_base, cl.dval);
        else if (alive[F_ZPFX] && (pos != 8'd1) && pfx_ok)
            acc_p_next = shift_in(state.acc_prefixed, state.pfx_base, cl.dval);

        acc_b_next = state.acc_binary;
        if (alive[F_SB] && !state.form_suffix[F_SB] && cl.is_bin)
            acc_b_next = shift_in(state.acc_binary, BASE_2, cl.dval);

        acc_o_next = state.acc_octal;
        if (alive[F_SO] && !state.form_suffix[F_SO] && cl.is_oct)
            acc_o_next = shift_in(state.acc_octal, BASE_8, cl.dval);

        acc_h_next = state.acc_hex;
        if (alive[F_SH] && !state.form_suffix[F_SH] && cl.is_hex)
            acc_h_next = shift_in(state.acc_hex, BASE_16, cl.dval);

        // Times ten as eight plus two.
        acc_d_next = state.acc_decimal;
        if (cl.is_dec && ((alive[F_SD] && !state.form_suffix[F_SD]) || alive[F_DEC]))
            acc_d_next = {state.acc_decimal[28:0], 3'b000} + {state.acc_decimal[30:0], 1'b0}
                         + {28'd0, cl.dval};
    end

    // The highest-priority success wins and retires every lower-priority form.
    always_comb
    begin
        win = F_DEC;
        for (int i = NUM_FORMS - 1; i >= 0; i--)
        begin
            if (succ[i])
                win = nlr_form_t'(i);
        end
        succ_any = |succ;
        take     = succ_any && (!state.best_valid || (win < state.best_rank));
        for (int i = 0; i < NUM_FORMS; i++)
            keep_mask[i] = 3'(i) < win;

        case (win)
            F_QUOTE: win_value = state.acc_prefixed;
            F_PDIG:  win_value = state.acc_prefixed;
            F_ZPFX:  win_value = state.acc_prefixed;
            F_SB:    win_value = state.acc_binary;
            F_SO:    win_value = state.acc_octal;
            F_SH:    win_value = state.acc_hex;
            default: win_value = state.acc_decimal;
        endcase

        alive_after      = alive & ~kill;
        best_valid_after = state.best_valid;
        best_rank_after  = state.best_rank;
        best_len_after   = state.best_len;
        best_value_after = state.best_value;
        if (take)
        begin
            alive_after      = alive_after & keep_mask;
            best_valid_after = 1'b1;
            best_rank_after  = win;
            // The closing quote of a bitmap is part of the token.
            best_len_after   = (win == F_QUOTE) ? pos_inc : pos;
            best_value_after = win_value;
        end
    end

    // Forms opened by the first character of a token.
    always_comb
    begin
        start_known = 1'b1;
        start_alive = '0;
        start_base  = BASE_2;
        start_bin   = '0;
        start_oct   = '0;
        start_dec   = '0;
        case (c)
            CH_HASH:
            begin
                if (cfg.hash_means_hex)
                begin
                    start_alive[F_PDIG] = 1'b1;
                    start_base          = BASE_16;
                end
            end
            CH_DOLLAR:
            begin
                start_alive[F_PDIG] = 1'b1;
                start_base          = BASE_16;
            end
            CH_PERCENT:
            begin
                start_alive[F_PDIG]  = 1'b1;
                start_alive[F_QUOTE] = 1'b1;
            end
            CH_AT:
            begin
                start_alive[F_PDIG]  = 1'b1;
                start_alive[F_QUOTE] = !cfg.at_means_octal;
                start_base           = cfg.at_means_octal ? BASE_8 : BASE_2;
            end
            default:
            begin
                if (cl.is_dec)
                begin
                    start_alive[F_ZPFX] = (c == CH_ZERO);
                    start_alive[F_SB]   = cl.is_bin;
                    start_alive[F_SO]   = cl.is_oct;
                    start_alive[F_SD]   = 1'b1;
                    start_alive[F_SH]   = 1'b1;
                    start_alive[F_DEC]  = 1'b1;
                    start_bin = cl.is_bin ? {28'd0, cl.dval} : '0;
                    start_oct = cl.is_oct ? {28'd0, cl.dval} : '0;
                    start_dec = {28'd0, cl.dval};
                end
                else
                begin
                    start_known = 1'b0;
                end
            end
        endcase
    end

    // Result of this beat.
    always_comb
    begin
        result_valid  = 1'b0;
        result.kind   = KIND_NUMBER;
        result.value  = '0;
        result.length = '0;
        if (item_valid)
        begin
            if (item.token_start)
            begin
                if (!start_known)
                begin
                    result_valid  = 1'b1;
                    result.kind   = KIND_INVALID;
                    result.length = 8'd1;
                end
                else if (start_alive == '0)
                begin
                    result_valid  = 1'b1;
                    result.kind   = op_kind(c);
                    result.length = 8'd1;
                end
            end
            else
            begin
                case (state.phase)
                    PH_SCAN:
                    begin
                        if (best_valid_after && ((alive_after == '0) || at_limit))
                        begin
                            result_valid  = 1'b1;
                            result.kind   = KIND_NUMBER;
                            result.value  = best_value_after;
                            result.length = best_len_after;
                        end
                        else if (alive_after == '0)
                        begin
                            if (lead_op != KIND_INVALID)
                            begin
                                result_valid  = 1'b1;
                                result.kind   = lead_op;
                                result.length = 8'd1;
                            end
                            else if (c == CH_NUL)
                            begin
                                result_valid  = 1'b1;
                                result.kind   = KIND_INVALID;
                                result.length = pos;
                            end
                            else if (at_limit)
                            begin
                                result_valid  = 1'b1;
                                result.kind   = KIND_INVALID;
                                result.length = MAX_TOKEN_LEN;
                            end
                        end
                        else if (at_limit)
                        begin
                            result_valid  = 1'b1;
                            result.kind   = KIND_INVALID;
                            result.length = MAX_TOKEN_LEN;
                        end
                    end
                    PH_DRAIN:
                    begin
                        if (c == CH_NUL)
                        begin
                            result_valid  = 1'b1;
                            result.kind   = KIND_INVALID;
                            result.length = pos;
                        end
                        else if (at_limit)
                        begin
                            result_valid  = 1'b1;
                            result.kind   = KIND_INVALID;
                            result.length = MAX_TOKEN_LEN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state;
        if (item_valid)
        begin
            if (item.token_start)
            begin
                state_next.phase        = result_valid ? PH_IDLE : PH_SCAN;
                state_next.char_count   = 8'd1;
                state_next.lead_char    = c;
                state_next.quote_char   = '0;
                state_next.form_alive   = start_alive;
                state_next.form_suffix  = '0;
                state_next.pfx_base     = start_base;
                state_next.acc_prefixed = '0;
                state_next.acc_binary   = start_bin;
                state_next.acc_octal    = start_oct;
                state_next.acc_decimal  = start_dec;
                state_next.acc_hex      = start_dec;
                state_next.best_valid   = 1'b0;
                state_next.best_rank    = F_QUOTE;
                state_next.best_len     = '0;
                state_next.best_value   = '0;
            end
            else
            begin
                case (state.phase)
                    PH_SCAN:
                    begin
                        if (result_valid)
                            state_next.phase = PH_IDLE;
                        else if (alive_after == '0)
                            state_next.phase = PH_DRAIN;
                        else
                            state_next.phase = PH_SCAN;
                        state_next.char_count = pos_inc;
                        if (alive[F_QUOTE] && (pos == 8'd1) && q_open)
                            state_next.quote_char = c;
                        if (alive[F_ZPFX] && (pos == 8'd1) && z_base_ok)
                            state_next.pfx_base = z_base;
                        state_next.form_alive   = alive_after;
                        state_next.form_suffix  = state.form_suffix | sfx_set;
                        state_next.acc_prefixed = acc_p_next;
                        state_next.acc_binary   = acc_b_next;
                        state_next.acc_octal    = acc_o_next;
                        state_next.acc_decimal  = acc_d_next;
                        state_next.acc_hex      = acc_h_next;
                        state_next.best_valid   = best_valid_after;
                        state_next.best_rank    = best_rank_after;
                        state_next.best_len     = best_len_after;
                        state_next.best_value   = best_value_after;
                    end
                    PH_DRAIN:
                    begin
                        state_next.phase      = result_valid ? PH_IDLE : PH_DRAIN;
                        state_next.char_count = pos_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/numeric_literal_recognizer.sv =====
// Top level: numeric literal recognizer with input register, scan logic and result register.
`default_nettype none

// Numeric literal recognizer. Characters of an assembler number token enter one
// beat at a time on the item channel, the first one flagged by token_start. All
// literal forms (#hex, $hex, %bin, @bin or @octal, quoted bitmaps, 0b/0o/0q/0x,
// suffixed b, o/q, d, h and plain decimal) are tracked side by side in 32-bit
// accumulators, the prefixed forms sharing one and suffixed d and plain decimal
// another, and the first form in priority order that completes decides the token.
// At most one result beat follows a character: kind, the value wrapped to 32 bits,
// and the number of characters consumed; characters past that count belong to
// the next token and must be sent again with token_start set. Throughput is one
// character per clock. A character is captured in an input register and goes
// through the scan logic once the result register can take its output, which the
// result register then captures. The input side keeps taking characters while a
// result waits; it stalls only when a character is held and the result register
// is full and not being taken. Configuration (hash_means_hex at index 0,
// at_means_octal at index 1) is written through the cfg channel, which is always
// ready; the values take effect at the next token start.
module numeric_literal_recognizer
    import nlr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_ready,
    input  nlr_item_t              item,

    output logic                   result_valid,
    input  logic                   result_ready,
    output nlr_result_t            result,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    nlr_cfg_t    cfg_reg;
    nlr_item_t   item_hold_reg;
    logic        item_held_reg;
    nlr_state_t  state_reg;
    nlr_state_t  state_next;
    nlr_result_t result_reg;
    logic        result_valid_reg;
    nlr_result_t scan_result;
    logic        scan_result_valid;
    logic        step_go;

    // The held character is processed when the result register can take
    // whatever it produces.
    assign step_go      = item_held_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_held_reg || step_go;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HASH_MEANS_HEX: cfg_reg.hash_means_hex <= cfg_data[0];
                CFG_AT_MEANS_OCTAL: cfg_reg.at_means_octal <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_held_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            item_held_reg <= 1'b1;
        end
        else if (step_go)
        begin
            item_held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_hold_reg <= item;
    end

    nlr_scan u_scan (
        .cfg          (cfg_reg),
        .item         (item_hold_reg),
        .item_valid   (step_go),
        .state        (state_reg),
        .state_next   (state_next),
        .result_valid (scan_result_valid),
        .result       (scan_result)
    );

    // Recognizer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step_go && scan_result_valid)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && scan_result_valid)
            result_reg <= scan_result;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench: self-checking regression for the numeric literal recognizer.
`timescale 1ns / 1ps

import nlr_pkg::*;

// Tracks every accepted character, predicts the token results that the
// recognizer must produce and checks the result beats against them in order.
class literal_tracker;

    // Register copies, updated when a configuration beat is accepted.
    logic hash_hex;
    logic at_oct;

    // Scan state of the token in progress.
    nlr_phase_t  phase;
    logic [7:0]  count;
    logic [7:0]  lead;
    logic [7:0]  quote;
    logic [7:0]  alive;
    logic [7:0]  sfx;
    logic [31:0] acc_pfx;
    logic [31:0] acc [NUM_FORMS];
    int unsigned pfx_base;
    bit          best_valid;
    int          best_rank;
    logic [7:0]  best_len;
    logic [31:0] best_value;

    nlr_result_t pending_literals[$];
    int failures;
    int checked;
    int chars_seen;
    int kind_seen [8];

    function new();
        hash_hex   = 1'b0;
        at_oct     = 1'b0;
        phase      = PH_IDLE;
        count      = '0;
        lead       = '0;
        quote      = '0;
        alive      = '0;
        sfx        = '0;
        acc_pfx    = '0;
        foreach (acc[i]) acc[i] = '0;
        pfx_base   = 2;
        best_valid = 1'b0;
        best_rank  = 0;
        best_len   = '0;
        best_value = '0;
        failures   = 0;
        checked    = 0;
        chars_seen = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_HASH_MEANS_HEX) hash_hex = data[0];
        else if (idx == CFG_AT_MEANS_OCTAL) at_oct = data[0];
    endfunction

    function int pending();
        return pending_literals.size();
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    // Letters, digits, underscore and dot continue an identifier.
    function bit is_ident(logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return c == CH_UNDERSCORE || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE)
            || (l >= CH_LOWER_A && l <= CH_LOWER_Z);
    endfunction

    // Digit value in the given base, or -1. Bitmaps also take '-' and '#'.
    function int digit_val(int base, bit bitmap, logic [7:0] c);
        logic [7:0] l;
        int v;
        l = to_lower(c);
        if (base == 2) begin
            if (c == CH_ZERO || (bitmap && c == CH_MINUS)) return 0;
            if (c == CH_ONE || (bitmap && c == CH_HASH)) return 1;
            return -1;
        end
        if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
        else if (l >= CH_LOWER_A && l <= CH_LOWER_Z) v = l - CH_LOWER_A + 10;
        else return -1;
        return (v < base) ? v : -1;
    endfunction

    function void produce(nlr_kind_t k, logic [31:0] v, int len);
        nlr_result_t r;
        r.kind   = k;
        r.value  = v;
        r.length = 8'(len);
        pending_literals.push_back(r);
        phase = PH_IDLE;
    endfunction

    // A completed form wins unless a higher-priority form already did; it also
    // retires every form of lower priority.
    function void succeed(int f, int len, logic [31:0] v);
        if (best_valid && f >= best_rank) return;
        best_valid = 1'b1;
        best_rank  = f;
        best_len   = 8'(len);
        best_value = v;
        for (int i = f; i < NUM_FORMS; i++) alive[i] = 1'b0;
    endfunction

    function void suffix_step(int f, int base, bit accumulate, logic [7:0] s1,
                              logic [7:0] s2, logic [7:0] c, int pos);
        int d;
        logic [7:0] l;
        if (!alive[f]) return;
        if (sfx[f]) begin
            alive[f] = 1'b0;
            if (!is_ident(c)) succeed(f, pos, acc[f]);
            return;
        end
        d = digit_val(base, 1'b0, c);
        if (d >= 0) begin
            if (accumulate) acc[f] = acc[f] * base + d;
            return;
        end
        l = to_lower(c);
        if (l == s1 || l == s2) sfx[f] = 1'b1;
        else alive[f] = 1'b0;
    endfunction

    // No form can finish: operator kinds for the #, $ and % leads, otherwise the
    // token is swallowed up to the end of the line.
    function void give_up(logic [7:0] c, int pos);
        if (lead == CH_HASH) produce(KIND_HASH, '0, 1);
        else if (lead == CH_DOLLAR) produce(KIND_LOC_COUNTER, '0, 1);
        else if (lead == CH_PERCENT) produce(KIND_MODULO, '0, 1);
        else if (c == CH_NUL) produce(KIND_INVALID, '0, pos);
        else if (pos >= MAX_TOKEN_LEN) produce(KIND_INVALID, '0, MAX_TOKEN_LEN);
        else begin
            phase = PH_DRAIN;
            count = 8'(pos + 1);
        end
    endfunction

    function void begin_token(logic [7:0] c);
        int dv;
        acc_pfx = '0;
        foreach (acc[i]) acc[i] = '0;
        alive      = '0;
        sfx        = '0;
        best_valid = 1'b0;
        best_rank  = 0;
        best_len   = '0;
        best_value = '0;
        lead       = c;
        quote      = '0;
        pfx_base   = 2;
        if (c == CH_HASH) begin
            if (hash_hex) begin
                alive[F_PDIG] = 1'b1;
                pfx_base = 16;
            end
        end else if (c == CH_DOLLAR) begin
            alive[F_PDIG] = 1'b1;
            pfx_base = 16;
        end else if (c == CH_PERCENT) begin
            alive[F_QUOTE] = 1'b1;
            alive[F_PDIG]  = 1'b1;
            pfx_base = 2;
        end else if (c == CH_AT) begin
            alive[F_PDIG] = 1'b1;
            if (!at_oct) alive[F_QUOTE] = 1'b1;
            pfx_base = at_oct ? 8 : 2;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            dv = c - CH_ZERO;
            if (c == CH_ZERO) alive[F_ZPFX] = 1'b1;
            if (dv < 2) begin
                alive[F_SB] = 1'b1;
                acc[F_SB] = dv;
            end
            if (dv < 8) begin
                alive[F_SO] = 1'b1;
                acc[F_SO] = dv;
            end
            alive[F_SD]  = 1'b1;
            alive[F_SH]  = 1'b1;
            alive[F_DEC] = 1'b1;
            acc[F_SD] = dv;
            acc[F_SH] = dv;
        end else begin
            produce(KIND_INVALID, '0, 1);
            return;
        end
        if (alive == '0) begin
            give_up(c, 0);
            return;
        end
        phase = PH_SCAN;
        count = 8'd1;
    endfunction

    function void scan(logic [7:0] c);
        int pos;
        int d;
        logic [7:0] l;
        pos = count;
        // Quoted bitmap: quote at position one, bitmap digits, same quote to close.
        if (alive[F_QUOTE]) begin
            if (pos == 1) begin
                if (c == CH_SQUOTE || c == CH_DQUOTE) quote = c;
                else alive[F_QUOTE] = 1'b0;
            end else begin
                d = digit_val(2, 1'b1, c);
                if (d >= 0) acc_pfx = acc_pfx * 2 + d;
                else begin
                    alive[F_QUOTE] = 1'b0;
                    if (pos > 2 && c == quote && pos + 1 <= MAX_TOKEN_LEN)
                        succeed(F_QUOTE, pos + 1, acc_pfx);
                end
            end
        end
        if (alive[F_PDIG]) begin
            d = digit_val(pfx_base, 1'b0, c);
            if (d >= 0) acc_pfx = acc_pfx * pfx_base + d;
            else begin
                alive[F_PDIG] = 1'b0;
                if (pos > 1 && !is_ident(c)) succeed(F_PDIG, pos, acc_pfx);
            end
        end
        if (alive[F_ZPFX]) begin
            if (pos == 1) begin
                l = to_lower(c);
                if (l == CH_LOWER_B) pfx_base = 2;
                else if (l == CH_LOWER_O || l == CH_LOWER_Q) pfx_base = 8;
                else if (l == CH_LOWER_X) pfx_base = 16;
                else alive[F_ZPFX] = 1'b0;
            end else begin
                d = digit_val(pfx_base, 1'b0, c);
                if (d >= 0) acc_pfx = acc_pfx * pfx_base + d;
                else begin
                    alive[F_ZPFX] = 1'b0;
                    if (pos > 2 && !is_ident(c)) succeed(F_ZPFX, pos, acc_pfx);
                end
            end
        end
        suffix_step(F_SB, 2, 1'b1, CH_LOWER_B, CH_LOWER_B, c, pos);
        suffix_step(F_SO, 8, 1'b1, CH_LOWER_O, CH_LOWER_Q, c, pos);
        // The decimal accumulator is shared by the d-suffix form and plain decimal.
        d = digit_val(10, 1'b0, c);
        if (d >= 0 && ((alive[F_SD] && !sfx[F_SD]) || alive[F_DEC]))
            acc[F_SD] = acc[F_SD] * 10 + d;
        suffix_step(F_SD, 10, 1'b0, CH_LOWER_D, CH_LOWER_D, c, pos);
        suffix_step(F_SH, 16, 1'b1, CH_LOWER_H, CH_LOWER_H, c, pos);
        if (alive[F_DEC] && d < 0) begin
            alive[F_DEC] = 1'b0;
            if (!is_ident(c)) succeed(F_DEC, pos, acc[F_SD]);
        end

        if (best_valid && (alive == '0 || pos >= MAX_TOKEN_LEN)) begin
            produce(KIND_NUMBER, best_value, best_len);
            return;
        end
        if (alive == '0) begin
            give_up(c, pos);
            return;
        end
        if (pos >= MAX_TOKEN_LEN) begin
            produce(KIND_INVALID, '0, MAX_TOKEN_LEN);
            return;
        end
        count = 8'(pos + 1);
    endfunction

    function void consume_char(nlr_item_t it);
        chars_seen++;
        if (it.token_start) begin_token(it.char_code);
        else if (phase == PH_SCAN) scan(it.char_code);
        else if (phase == PH_DRAIN) begin
            if (it.char_code == CH_NUL) produce(KIND_INVALID, '0, count);
            else if (count >= MAX_TOKEN_LEN) produce(KIND_INVALID, '0, MAX_TOKEN_LEN);
            else count = count + 8'd1;
        end
    endfunction

    function void compare_literal(nlr_result_t got);
        nlr_result_t exp_r;
        kind_seen[got.kind]++;
        if (pending_literals.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: result with nothing pending: kind %0d value %h length %0d",
                         got.kind, got.value, got.length);
            return;
        end
        exp_r = pending_literals.pop_front();
        checked++;
        if (got.kind !== exp_r.kind || got.value !== exp_r.value
            || got.length !== exp_r.length) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: expected kind %0d value %h length %0d, got kind %0d value %h length %0d",
                         exp_r.kind, exp_r.value, exp_r.length,
                         got.kind, got.value, got.length);
        end
    endfunction

    function void close_out();
        if (pending_literals.size() != 0) begin
            failures += pending_literals.size();
            $display("ERROR: %0d results never arrived", pending_literals.size());
        end
    endfunction

endclass

module tb;

    // Cycles of quiet after the last result before a register write or the end.
    localparam int QUIET_CYCLES  = 6;
    // Receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD     = 64;
    // Characters per random phase; four phases make up the random part.
    localparam int PHASE_CHARS   = 215;

    // Characters used by the stimulus that the package does not name.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    nlr_item_t              item;
    logic                   result_valid;
    logic                   result_ready;
    nlr_result_t            result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    literal_tracker tracker;

    // Sender and receiver controls, changed by the main sequence between phases.
    int   ready_mode;
    bit   hold_req;
    bit   gaps_on;
    int   burst_left;
    int   tokens_sent;
    int   settings_used;
    logic at_oct_now;

    numeric_literal_recognizer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Every handshake is observed here on the clock edge, so the prediction sees
    // characters, register writes and results exactly in the order the block did.
    // A character is noted before a result is checked in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
            if (item_valid && item_ready) tracker.consume_char(item);
            if (result_valid && result_ready) tracker.compare_literal(result);
        end
    end

    // Receiver. It runs its own stall pattern and, when asked, holds ready low for
    // a long stretch that it counts itself while the sender keeps offering beats.
    initial
    begin : receiver
        int cyc;
        int hold_left;
        cyc = 0;
        hold_left = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    2:       result_ready <= ($urandom_range(0, 9) < 8);
                    3:       result_ready <= (cyc % 4 != 0);
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: a correct run finishes far inside this time.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offers one character beat and returns at the edge where it is taken. When a
    // burst runs out with gaps on, valid drops for a random gap before the next burst.
    task automatic send_char(input logic [7:0] c, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = gaps_on ? $urandom_range(1, 16) : 1_000_000;
            gap = $urandom_range(0, 5);
            if (gaps_on && gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= {c, st};
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Sends a token text with token_start on its first character, then the
    // character that follows the token.
    task automatic send_text(input string s, input logic [7:0] term);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
        send_char(term, 1'b0);
        tokens_sent++;
    endtask

    // Long tokens for the length limit: a head, n repeats of one character and a
    // closing character.
    task automatic send_long(input string head, input logic [7:0] fill, input int n,
                             input logic [7:0] term);
        for (int i = 0; i < head.len(); i++) send_char(head[i], i == 0);
        repeat (n) send_char(fill, 1'b0);
        send_char(term, 1'b0);
        tokens_sent++;
    endtask

    // Writes both registers back to back; valid stays high across the two beats.
    task automatic apply_settings(input logic hex_hash, input logic oct_at);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HASH_MEANS_HEX;
        cfg_data  <= hex_hash;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_AT_MEANS_OCTAL;
        cfg_data  <= oct_at;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        at_oct_now = oct_at;
        settings_used++;
    endtask

    // Stops offering characters and waits until every predicted result has been
    // taken, then waits QUIET_CYCLES more for a character that produces nothing.
    task automatic wait_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] maybe_upper(input logic [7:0] c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 1))
            return c - CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] pick_digit(input int base);
        int v;
        v = $urandom_range(0, base - 1);
        if (v < 10) return CH_ZERO + 8'(v);
        return maybe_upper(CH_LOWER_A + 8'(v - 10));
    endfunction

    function automatic logic [7:0] pick_bitmap();
        case ($urandom_range(0, 3))
            0:       return CH_MINUS;
            1:       return CH_HASH;
            2:       return CH_ZERO;
            default: return CH_ONE;
        endcase
    endfunction

    // Mostly separators that end a literal, sometimes an identifier character or
    // a high byte.
    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 11))
            0, 1, 2: return CH_SPACE;
            3:       return CH_NUL;
            4:       return CH_COMMA;
            5:       return CH_RPAREN;
            6:       return 8'h80 | 8'($urandom_range(0, 127));
            7:       return CH_UNDERSCORE;
            8:       return CH_DOT;
            9:       return maybe_upper(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            default: return CH_PLUS;
        endcase
    endfunction

    // One random token. Most are well-formed literals of every form with random
    // digits; the rest are raw noise bytes or literals with one byte corrupted.
    task automatic send_random_token();
        logic [7:0] text[$];
        logic [7:0] q;
        int sel;
        int n;
        int base;
        int spot;
        text = {};
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            // Prefixed digits.
            case ($urandom_range(0, 3))
                0:       begin text.push_back(CH_HASH);    base = 16; end
                1:       begin text.push_back(CH_DOLLAR);  base = 16; end
                2:       begin text.push_back(CH_PERCENT); base = 2;  end
                default: begin text.push_back(CH_AT);      base = at_oct_now ? 8 : 2; end
            endcase
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            repeat (n) text.push_back(pick_digit(base));
        end
        else if (sel < 25)
        begin
            // Quoted bitmap, now and then with a mismatched closing quote.
            text.push_back($urandom_range(0, 1) ? CH_PERCENT : CH_AT);
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            text.push_back(q);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (n) text.push_back(pick_bitmap());
            if ($urandom_range(0, 9) == 0) text.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
            else text.push_back(q);
        end
        else if (sel < 40)
        begin
            // Zero prefix.
            text.push_back(CH_ZERO);
            case ($urandom_range(0, 3))
                0:       begin text.push_back(maybe_upper(CH_LOWER_B)); base = 2;  end
                1:       begin text.push_back(maybe_upper(CH_LOWER_O)); base = 8;  end
                2:       begin text.push_back(maybe_upper(CH_LOWER_Q)); base = 8;  end
                default: begin text.push_back(maybe_upper(CH_LOWER_X)); base = 16; end
            endcase
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            repeat (n) text.push_back(pick_digit(base));
        end
        else if (sel < 70)
        begin
            // Suffix forms; the first character is always a decimal digit.
            case ($urandom_range(0, 3))
                0:       base = 2;
                1:       base = 8;
                2:       base = 10;
                default: base = 16;
            endcase
            text.push_back(pick_digit(base < 10 ? base : 10));
            n = $urandom_range(0, 8);
            repeat (n) text.push_back(pick_digit(base));
            case (base)
                2:       text.push_back(maybe_upper(CH_LOWER_B));
                8:       text.push_back(maybe_upper($urandom_range(0, 1) ? CH_LOWER_O : CH_LOWER_Q));
                10:      text.push_back(maybe_upper(CH_LOWER_D));
                default: text.push_back(maybe_upper(CH_LOWER_H));
            endcase
        end
        else if (sel < 85)
        begin
            // Plain decimal, long enough at times to wrap past 32 bits.
            n = $urandom_range(1, 12);
            repeat (n) text.push_back(pick_digit(10));
        end
        else if (sel < 93)
        begin
            // Noise: any byte, with token_start set at random inside the run.
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 3) == 0));
            tokens_sent++;
            return;
        end
        else
        begin
            // A decimal literal with one byte replaced.
            n = $urandom_range(2, 8);
            repeat (n) text.push_back(pick_digit(10));
            spot = $urandom_range(0, n - 1);
            text[spot] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < text.size(); i++) send_char(text[i], i == 0);
        send_char(pick_terminator(), 1'b0);
        tokens_sent++;
    endtask

    initial
    begin : main
        int start_chars;
        tracker       = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        ready_mode    = 0;
        hold_req      = 1'b0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        tokens_sent   = 0;
        settings_used = 0;
        at_oct_now    = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tokens with both registers clear: every form, the operator
        // fallbacks, draining to end of line and the odd first characters.
        apply_settings(1'b0, 1'b0);
        ready_mode = 1;
        send_text("$1F", CH_SPACE);
        send_text("$", CH_SPACE);
        send_text("#", CH_SPACE);
        send_text("%1010", CH_SPACE);
        send_text("%", CH_SPACE);
        send_text("%'-#01'", CH_SPACE);
        send_text("@'#--#'", CH_SPACE);
        send_text("%'01\"", CH_SPACE);
        send_text("@101", CH_NUL);
        send_text("0b101", CH_SPACE);
        send_text("0o17", CH_COMMA);
        send_text("0Q17", CH_SPACE);
        send_text("0xffFFffFF1", CH_SPACE);
        send_text("101b", CH_SPACE);
        send_text("17O", CH_SPACE);
        send_text("17q", CH_SPACE);
        send_text("99D", CH_SPACE);
        send_text("0FFh", CH_SPACE);
        send_text("4294967297", CH_SPACE);
        send_text("12ab", CH_NUL);
        send_text("12abz.x", CH_NUL);
        send_text("$1g", CH_SPACE);
        send_text("z", CH_SPACE);
        send_char(CH_NUL, 1'b1);
        send_char(8'hFF, 1'b1);
        // A new token start in the middle of a token drops the old one.
        send_char(CH_ONE, 1'b1);
        send_char(CH_NINE, 1'b0);
        send_text("5", CH_SPACE);
        // Characters without a token start while idle are ignored.
        send_char(8'hA5, 1'b0);
        wait_quiet();

        // Hash as hex and at as octal.
        apply_settings(1'b1, 1'b1);
        send_text("#1fF", CH_SPACE);
        send_text("#", CH_SPACE);
        send_text("@17", CH_SPACE);
        send_text("@8", CH_NUL);
        send_text("@'#'", CH_NUL);
        wait_quiet();

        // Length limit, at full rate with no stalls on either side.
        apply_settings(1'b0, 1'b0);
        ready_mode = 0;
        gaps_on    = 1'b0;
        burst_left = 0;
        send_long("$", CH_LOWER_F, 253, CH_SPACE);
        send_long("$", CH_LOWER_F, 254, CH_SPACE);
        send_long("$", CH_LOWER_F, 270, CH_SPACE);
        send_long("1", CH_SEVEN, 270, CH_SPACE);
        send_long("1", CH_LOWER_Z, 270, CH_SPACE);
        send_long("%'", CH_HASH, 252, CH_SQUOTE);
        send_long("%'", CH_HASH, 253, CH_SQUOTE);
        wait_quiet();

        // Back-pressure: the receiver stops for a long stretch while characters without
        // token_start keep coming; an idle block ignores them, so no result is produced.
        hold_req = 1'b1;
        repeat (40) send_text("", CH_LOWER_Z);
        wait_quiet();

        // Random tokens under four register settings and four stall patterns.
        for (int p = 0; p < 4; p++)
        begin
            apply_settings(p == 1 || p == 2, p == 0 || p == 2);
            ready_mode = p + 1;
            gaps_on    = (p != 2);
            burst_left = 0;
            start_chars = tracker.chars_seen;
            while (tracker.chars_seen - start_chars < PHASE_CHARS) send_random_token();
            wait_quiet();
        end

        tracker.close_out();
        $display("Covered %0d tokens in %0d characters under %0d register settings, %0d results checked.",
                 tokens_sent, tracker.chars_seen, settings_used, tracker.checked);
        $display("Result kinds: number %0d, hash %0d, location counter %0d, modulo %0d, invalid %0d.",
                 tracker.kind_seen[KIND_NUMBER], tracker.kind_seen[KIND_HASH],
                 tracker.kind_seen[KIND_LOC_COUNTER], tracker.kind_seen[KIND_MODULO],
                 tracker.kind_seen[KIND_INVALID]);
        if (tracker.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
